/* design/mpte_pkg.sv */
// Package for the multivariate polynomial term evaluator.
// Holds the word types, the register indexes, the control word format and the microcode ROM.
// No dependencies.
`default_nettype none

package mpte_pkg;

   localparam int EXP_BITS   = 4;
   localparam int COEF_W     = 16;
   localparam int VAR_W      = 16;
   localparam int EXP_W      = 4;
   localparam int DATA_W     = 32;
   localparam int CSR_IDX_W  = 2;
   localparam int PC_W       = 4;

   localparam logic [CSR_IDX_W-1:0] CSR_X_VALUE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_Y_VALUE = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_Z_VALUE = 2'd2;

   typedef struct packed {
      logic signed [COEF_W-1:0] coefficient;
      logic [EXP_W-1:0]         exp_x;
      logic [EXP_W-1:0]         exp_y;
      logic [EXP_W-1:0]         exp_z;
      logic                     last_term;
   } req_word_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] poly_value;
      logic                     overflowed;
   } rsp_word_type;

   // Datapath operation of one microcode step.
   typedef enum logic [1:0] {
      OP_LOAD  = 2'd0,  // accumulator <= 1, counter <= selected exponent
      OP_POW   = 2'd1,  // accumulator <= sat(accumulator * selected variable)
      OP_MULT  = 2'd2,  // term <= sat(term or coefficient * accumulator)
      OP_ACCUM = 2'd3   // running sum <= sat(sum + term), emit on last
   } op_type;

   typedef enum logic [1:0] {
      VAR_X = 2'd0,
      VAR_Y = 2'd1,
      VAR_Z = 2'd2
   } var_sel_type;

   typedef enum logic {
      JMP_NONE   = 1'b0,
      JMP_CNT_NZ = 1'b1
   } jmp_type;

   typedef struct packed {
      op_type           op;
      var_sel_type      var_sel;
      logic             coef_src;
      jmp_type          jmp;
      logic [PC_W-1:0]  target;
   } ucode_word_type;

   localparam logic [PC_W-1:0] PC_START = 4'd0;

   // The microprogram: build x^ex, fold it into the coefficient, then y and z,
   // then accumulate. A power step loops on itself while the counter is nonzero.
   function automatic ucode_word_type ucode_rom(input logic [PC_W-1:0] pc);
      ucode_word_type w;
      w = '{op: OP_ACCUM, var_sel: VAR_X, coef_src: 1'b0, jmp: JMP_NONE, target: PC_START};
      case (pc)
         4'd0: w = '{op: OP_LOAD,  var_sel: VAR_X, coef_src: 1'b0, jmp: JMP_NONE,
                     target: PC_START};
         4'd1: w = '{op: OP_POW,   var_sel: VAR_X, coef_src: 1'b0, jmp: JMP_CNT_NZ,
                     target: 4'd1};
         4'd2: w = '{op: OP_MULT,  var_sel: VAR_X, coef_src: 1'b1, jmp: JMP_NONE,
                     target: PC_START};
         4'd3: w = '{op: OP_LOAD,  var_sel: VAR_Y, coef_src: 1'b0, jmp: JMP_NONE,
                     target: PC_START};
         4'd4: w = '{op: OP_POW,   var_sel: VAR_Y, coef_src: 1'b0, jmp: JMP_CNT_NZ,
                     target: 4'd4};
         4'd5: w = '{op: OP_MULT,  var_sel: VAR_Y, coef_src: 1'b0, jmp: JMP_NONE,
                     target: PC_START};
         4'd6: w = '{op: OP_LOAD,  var_sel: VAR_Z, coef_src: 1'b0, jmp: JMP_NONE,
                     target: PC_START};
         4'd7: w = '{op: OP_POW,   var_sel: VAR_Z, coef_src: 1'b0, jmp: JMP_CNT_NZ,
                     target: 4'd7};
         4'd8: w = '{op: OP_MULT,  var_sel: VAR_Z, coef_src: 1'b0, jmp: JMP_NONE,
                     target: PC_START};
         default: w = '{op: OP_ACCUM, var_sel: VAR_X, coef_src: 1'b0, jmp: JMP_NONE,
                        target: PC_START};
      endcase
      return w;
   endfunction

endpackage

`default_nettype wire

/* design/multivar_poly_term_evaluator_core.sv */
// Top level of the multivariate polynomial term evaluator.
// Uses mpte_pkg (types, microcode ROM) and mpte_sat_mul (shared saturating multiplier).
`default_nettype none

// Evaluates a polynomial in x, y and z that arrives one term per request word.
// The point (x, y, z) is set through the CSR port (index 0, 1, 2; other indexes are
// ignored); the user must write it only while the block is idle, as the block itself
// does not enforce this. Each term coefficient*x^ex*y^ey*z^ez is built by a small
// microprogram that drives one shared 32x32 saturating multiplier: each power is formed
// by ex (ey, ez) repeated multiplies from one, and the coefficient product takes three
// more. While a term is in progress the block stalls new words; the next word is taken
// only after the term's accumulate step. Every product and the running sum saturate to
// 32 bits and set a sticky overflow flag. On a word marked last_term the sum and the
// flag are written to the response register and both are cleared. The response
// register lets the next polynomial start while the result waits; the final step of a
// last term holds only while an earlier result is still stalled.
module multivar_poly_term_evaluator_core (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_valid,
   output logic                                    req_stall,
   input  wire mpte_pkg::req_word_type             req_data,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_stall,
   output mpte_pkg::rsp_word_type                  rsp_data,
   input  wire logic                               csr_valid,
   output logic                                    csr_ready,
   input  wire logic [mpte_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [mpte_pkg::VAR_W-1:0]         csr_data
);

   localparam int DW = mpte_pkg::DATA_W;

   // Configuration registers.
   logic signed [mpte_pkg::VAR_W-1:0] x_ff, x_in;
   logic signed [mpte_pkg::VAR_W-1:0] y_ff, y_in;
   logic signed [mpte_pkg::VAR_W-1:0] z_ff, z_in;

   // Sequencer and datapath registers.
   logic                            busy_ff, busy_in;
   logic [mpte_pkg::PC_W-1:0]       pc_ff, pc_in;
   logic [mpte_pkg::EXP_BITS-1:0]   cnt_ff, cnt_in;
   mpte_pkg::req_word_type          word_ff, word_in;
   logic signed [DW-1:0]            acc_ff, acc_in;
   logic signed [DW-1:0]            term_ff, term_in;
   logic signed [DW-1:0]            sum_ff, sum_in;
   logic                            sticky_ff, sticky_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   mpte_pkg::rsp_word_type          rsp_data_ff, rsp_data_in;

   mpte_pkg::ucode_word_type        step;
   logic signed [DW-1:0]            base;
   logic [mpte_pkg::EXP_W-1:0]      exp_sel;
   logic signed [DW-1:0]            mul_a, mul_b, mul_y;
   logic                            mul_ov;
   logic signed [DW:0]              sum_wide;
   logic signed [DW-1:0]            sum_sat;
   logic                            add_ov;
   logic                            cnt_nz;
   logic                            out_free;
   logic                            req_take;
   logic [mpte_pkg::PC_W-1:0]       pc_next;

   assign req_stall = busy_ff;
   assign req_take  = req_valid && !busy_ff;
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   assign step   = mpte_pkg::ucode_rom(pc_ff);
   assign cnt_nz = (cnt_ff != '0);

   // Operand selection for the shared multiplier.
   always_comb begin
      case (step.var_sel)
         mpte_pkg::VAR_X: begin
            base    = DW'(x_ff);
            exp_sel = word_ff.exp_x;
         end
         mpte_pkg::VAR_Y: begin
            base    = DW'(y_ff);
            exp_sel = word_ff.exp_y;
         end
         mpte_pkg::VAR_Z: begin
            base    = DW'(z_ff);
            exp_sel = word_ff.exp_z;
         end
         default: begin
            base    = DW'(x_ff);
            exp_sel = word_ff.exp_x;
         end
      endcase
      if (step.op == mpte_pkg::OP_POW) begin
         mul_a = acc_ff;
         mul_b = base;
      end else begin
         mul_a = step.coef_src ? DW'(word_ff.coefficient) : term_ff;
         mul_b = acc_ff;
      end
   end

   mpte_sat_mul u_mul (
      .a  (mul_a),
      .b  (mul_b),
      .y  (mul_y),
      .ov (mul_ov)
   );

   // Saturating accumulation of the finished term.
   always_comb begin
      sum_wide = (DW+1)'(sum_ff) + (DW+1)'(term_ff);
      add_ov   = (sum_wide[DW] != sum_wide[DW-1]);
      if (!add_ov) begin
         sum_sat = sum_wide[DW-1:0];
      end else if (sum_wide[DW]) begin
         sum_sat = {1'b1, {(DW-1){1'b0}}};
      end else begin
         sum_sat = {1'b0, {(DW-1){1'b1}}};
      end
   end

   // Next step: a conditional jump is taken while the loop counter is nonzero.
   always_comb begin
      if (step.jmp == mpte_pkg::JMP_CNT_NZ && cnt_nz) begin
         pc_next = step.target;
      end else begin
         pc_next = pc_ff + mpte_pkg::PC_W'(1);
      end
   end

   always_comb begin
      x_in         = x_ff;
      y_in         = y_ff;
      z_in         = z_ff;
      busy_in      = busy_ff;
      pc_in        = pc_ff;
      cnt_in       = cnt_ff;
      word_in      = word_ff;
      acc_in       = acc_ff;
      term_in      = term_ff;
      sum_in       = sum_ff;
      sticky_in    = sticky_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;

      if (csr_valid) begin
         case (csr_index)
            mpte_pkg::CSR_X_VALUE: x_in = csr_data;
            mpte_pkg::CSR_Y_VALUE: y_in = csr_data;
            mpte_pkg::CSR_Z_VALUE: z_in = csr_data;
            default: ;
         endcase
      end

      if (req_take) begin
         word_in = req_data;
         busy_in = 1'b1;
         pc_in   = mpte_pkg::PC_START;
      end else if (busy_ff) begin
         case (step.op)
            mpte_pkg::OP_LOAD: begin
               acc_in = DW'(1);
               cnt_in = mpte_pkg::EXP_BITS'(exp_sel);
               pc_in  = pc_next;
            end
            mpte_pkg::OP_POW: begin
               if (cnt_nz) begin
                  acc_in    = mul_y;
                  cnt_in    = cnt_ff - mpte_pkg::EXP_BITS'(1);
                  sticky_in = sticky_ff || mul_ov;
               end
               pc_in = pc_next;
            end
            mpte_pkg::OP_MULT: begin
               term_in   = mul_y;
               sticky_in = sticky_ff || mul_ov;
               pc_in     = pc_next;
            end
            mpte_pkg::OP_ACCUM: begin
               if (!word_ff.last_term) begin
                  sum_in    = sum_sat;
                  sticky_in = sticky_ff || add_ov;
                  busy_in   = 1'b0;
                  pc_in     = mpte_pkg::PC_START;
               end else if (out_free) begin
                  rsp_data_in.poly_value = sum_sat;
                  rsp_data_in.overflowed = sticky_ff || add_ov;
                  rsp_valid_in           = 1'b1;
                  sum_in                 = '0;
                  sticky_in              = 1'b0;
                  busy_in                = 1'b0;
                  pc_in                  = mpte_pkg::PC_START;
               end
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         x_ff         <= '0;
         y_ff         <= '0;
         z_ff         <= '0;
         busy_ff      <= 1'b0;
         pc_ff        <= mpte_pkg::PC_START;
         cnt_ff       <= '0;
         sum_ff       <= '0;
         sticky_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         x_ff         <= x_in;
         y_ff         <= y_in;
         z_ff         <= z_in;
         busy_ff      <= busy_in;
         pc_ff        <= pc_in;
         cnt_ff       <= cnt_in;
         sum_ff       <= sum_in;
         sticky_ff    <= sticky_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      word_ff     <= word_in;
      acc_ff      <= acc_in;
      term_ff     <= term_in;
      rsp_data_ff <= rsp_data_in;
   end

   // A result appears only out of the final step of a last term.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(busy_ff && step.op == mpte_pkg::OP_ACCUM
                                    && word_ff.last_term))
      else $error("response raised outside the accumulate step of a last term");

   // Emitting a result clears the running state for the next polynomial.
   assert property (@(posedge clock) disable iff (reset)
      (busy_ff && !req_take && step.op == mpte_pkg::OP_ACCUM && word_ff.last_term
       && out_free) |=> (sum_ff == '0 && !sticky_ff && !busy_ff))
      else $error("state not cleared after a result");

   // An idle sequencer always sits at the start of the program.
   assert property (@(posedge clock) disable iff (reset)
      !busy_ff |-> (pc_ff == mpte_pkg::PC_START))
      else $error("idle sequencer away from the start step");

   // A stalled result is never overwritten.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stall) |=> (rsp_valid_ff && $stable(rsp_data_ff)))
      else $error("stalled result overwritten");

endmodule

`default_nettype wire

/* design/mpte_sat_mul.sv */
// Signed 32 by 32 multiplier with saturation to the signed 32-bit range.
// Uses widths from mpte_pkg.
`default_nettype none

module mpte_sat_mul (
   input  wire logic signed [mpte_pkg::DATA_W-1:0] a,
   input  wire logic signed [mpte_pkg::DATA_W-1:0] b,
   output logic signed [mpte_pkg::DATA_W-1:0]      y,
   output logic                                    ov
);

   localparam int PW = 2 * mpte_pkg::DATA_W;

   logic signed [PW-1:0] prod;
   logic signed [PW-1:0] max_v;
   logic signed [PW-1:0] min_v;

   always_comb begin
      prod  = PW'(a) * PW'(b);
      max_v = PW'({1'b0, {(mpte_pkg::DATA_W-1){1'b1}}});
      min_v = -max_v - PW'(1);
      if (prod > max_v) begin
         y  = {1'b0, {(mpte_pkg::DATA_W-1){1'b1}}};
         ov = 1'b1;
      end else if (prod < min_v) begin
         y  = {1'b1, {(mpte_pkg::DATA_W-1){1'b0}}};
         ov = 1'b1;
      end else begin
         y  = prod[mpte_pkg::DATA_W-1:0];
         ov = 1'b0;
      end
   end

endmodule

`default_nettype wire

/* sim/tb_top.sv */
// Self-checking testbench for multivar_poly_term_evaluator_core.
// Streams polynomial term words under several points and idle patterns and checks every result
// word against an in-bench saturating predictor. Depends on mpte_pkg and the core RTL only.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   // Writes to this index must be ignored by the block.
   localparam logic [mpte_pkg::CSR_IDX_W-1:0] CSR_UNUSED_IDX = 2'd3;
   localparam longint MAX32 = 64'sd2147483647;
   localparam longint MIN32 = -64'sd2147483648;
   // Settle time, longer than the slowest term can occupy the core, so this long
   // after the last result word the core is certainly idle again.
   localparam int SETTLE_CYCLES = 80;
   localparam int RANDOM_PHASES = 8;
   localparam int TERMS_PER_PHASE = 200;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic req_valid = 1'b0;
   logic req_stall;
   mpte_pkg::req_word_type req_data = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   mpte_pkg::rsp_word_type rsp_data;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [mpte_pkg::CSR_IDX_W-1:0] csr_index = '0;
   logic [mpte_pkg::VAR_W-1:0] csr_data = '0;

   // Term words waiting to be sent, and result words the predictor has produced
   // but the core has not yet delivered.
   mpte_pkg::req_word_type pending_terms[$];
   mpte_pkg::rsp_word_type expected_results[$];

   // Predictor state: the evaluation point and the partial polynomial.
   int point_x = 0;
   int point_y = 0;
   int point_z = 0;
   int running_total = 0;
   bit sticky_sat = 1'b0;

   int send_idle_pct = 0;
   int stall_pct = 0;
   int mismatch_count = 0;

   multivar_poly_term_evaluator_core dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data(rsp_data),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   always #5 clock = ~clock;

   // Generous ceiling: the slowest legal run is well below a tenth of this.
   initial begin
      #10_000_000;
      $display("Mismatches found");
      $finish;
   end

   // ---------------------------------------------------------------------------
   // Saturating arithmetic of the predictor. Every product and every addition is
   // clamped to the signed 32-bit range, and any clamp raises the overflow flag.
   // ---------------------------------------------------------------------------
   function automatic int clamp32(input longint v, inout bit ov);
      if (v > MAX32) begin
         ov = 1'b1;
         return int'(MAX32);
      end
      if (v < MIN32) begin
         ov = 1'b1;
         return int'(MIN32);
      end
      return int'(v);
   endfunction

   function automatic int mul_clamped(input int a, input int b, inout bit ov);
      return clamp32(longint'(a) * longint'(b), ov);
   endfunction

   // Powers are built by repeated multiplication from one, clamping at each step,
   // so any base raised to zero (zero itself included) gives one.
   function automatic int raise_clamped(input int base, input logic [mpte_pkg::EXP_W-1:0] e,
                                        inout bit ov);
      int acc;
      acc = 1;
      for (int i = 0; i < int'(e); i++) begin
         acc = mul_clamped(acc, base, ov);
      end
      return acc;
   endfunction

   // Folds one accepted term word into the partial polynomial. On the last term
   // the finished value and its flag become an expected result word, and the
   // partial state is cleared for the next polynomial.
   task automatic fold_term(input mpte_pkg::req_word_type w);
      int px;
      int py;
      int pz;
      int term;
      bit ov;
      mpte_pkg::rsp_word_type r;
      ov = 1'b0;
      px = raise_clamped(point_x, w.exp_x, ov);
      py = raise_clamped(point_y, w.exp_y, ov);
      pz = raise_clamped(point_z, w.exp_z, ov);
      // The order matters: a clamped partial product that is later multiplied by
      // zero gives a zero term, yet the flag it raised stays set.
      term = mul_clamped(int'(w.coefficient), px, ov);
      term = mul_clamped(term, py, ov);
      term = mul_clamped(term, pz, ov);
      running_total = clamp32(longint'(running_total) + longint'(term), ov);
      if (ov) begin
         sticky_sat = 1'b1;
      end
      if (w.last_term) begin
         r.poly_value = running_total;
         r.overflowed = sticky_sat;
         expected_results.push_back(r);
         running_total = 0;
         sticky_sat = 1'b0;
      end
   endtask

   // ---------------------------------------------------------------------------
   // Term driver. A new word is only presented once the previous one has been
   // taken, so valid never looks at the current stall and a stalled word holds.
   // The word taken at this edge is handed to the predictor right here.
   // ---------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            fold_term(req_data);
         end
         if (!req_valid || !req_stall) begin
            if (pending_terms.size() != 0 && int'($urandom_range(99)) >= send_idle_pct) begin
               req_data <= pending_terms.pop_front();
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Result receiver: stalls at random with the current percentage.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= int'($urandom_range(99)) < stall_pct;
      end
   end

   // Result monitor. Each word taken is checked field by field against the
   // oldest expectation; a word with nothing expected is a failure as well.
   always @(posedge clock) begin
      mpte_pkg::rsp_word_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_results.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
               $display("%0t: unexpected result word: poly_value %0d overflowed %0b",
                        $realtime, rsp_data.poly_value, rsp_data.overflowed);
            end
         end else begin
            want = expected_results.pop_front();
            if (rsp_data.poly_value !== want.poly_value ||
                rsp_data.overflowed !== want.overflowed) begin
               mismatch_count++;
               if (mismatch_count <= 10) begin
                  $display("%0t: poly_value exp %0d got %0d, overflowed exp %0b got %0b",
                           $realtime, want.poly_value, rsp_data.poly_value,
                           want.overflowed, rsp_data.overflowed);
               end
            end
         end
      end
   end

   // ---------------------------------------------------------------------------
   // Stimulus helpers.
   // ---------------------------------------------------------------------------
   function automatic mpte_pkg::req_word_type make_term(input int coef, input int ex,
                                                        input int ey, input int ez,
                                                        input bit last);
      mpte_pkg::req_word_type w;
      w.coefficient = 16'(coef);
      w.exp_x = mpte_pkg::EXP_W'(ex);
      w.exp_y = mpte_pkg::EXP_W'(ey);
      w.exp_z = mpte_pkg::EXP_W'(ez);
      w.last_term = last;
      return w;
   endfunction

   // Mostly small exponents keep the values away from the clamp; the full range
   // still shows up often enough to push powers into saturation.
   function automatic int random_exp();
      int r;
      r = int'($urandom_range(9));
      if (r < 7) begin
         return int'($urandom_range(3));
      end else if (r < 9) begin
         return int'($urandom_range(7));
      end
      return int'($urandom_range(15));
   endfunction

   function automatic int random_signed16();
      int r;
      r = int'($urandom_range(9));
      if (r < 5) begin
         return int'($urandom_range(16)) - 8;
      end else if (r < 9) begin
         return int'($signed(16'($urandom)));
      end
      case ($urandom_range(4))
         0: return -32768;
         1: return 32767;
         2: return -1;
         3: return 1;
         default: return 0;
      endcase
   endfunction

   // Coordinates of a random point lean to small magnitudes so that sums of
   // several terms stay meaningful instead of always clamping.
   function automatic int random_coord();
      if ($urandom_range(1) == 0) begin
         return int'($urandom_range(8)) - 4;
      end
      return random_signed16();
   endfunction

   // Writes one register. Valid is left high so that back-to-back writes never
   // lower and raise it within one step; write_point drops it at the end.
   task automatic write_reg(input logic [mpte_pkg::CSR_IDX_W-1:0] idx,
                            input logic [mpte_pkg::VAR_W-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      do begin
         @(posedge clock);
      end while (!csr_ready);
      case (idx)
         mpte_pkg::CSR_X_VALUE: point_x = int'($signed(val));
         mpte_pkg::CSR_Y_VALUE: point_y = int'($signed(val));
         mpte_pkg::CSR_Z_VALUE: point_z = int'($signed(val));
         default: ;
      endcase
   endtask

   // Sets the evaluation point. A junk write to the unused index goes first and
   // must leave all three coordinates alone.
   task automatic write_point(input int xv, input int yv, input int zv);
      write_reg(CSR_UNUSED_IDX, 16'($urandom));
      write_reg(mpte_pkg::CSR_X_VALUE, 16'(xv));
      write_reg(mpte_pkg::CSR_Y_VALUE, 16'(yv));
      write_reg(mpte_pkg::CSR_Z_VALUE, 16'(zv));
      csr_valid <= 1'b0;
   endtask

   // Waits until every queued word is taken and every expected result has
   // arrived, then lets the core run dry before the point may change.
   task automatic settle();
      while (pending_terms.size() != 0 || req_valid || expected_results.size() != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Idle patterns: none, sender idle, receiver stalling, both.
   task automatic set_idle_mode(input int mode);
      case (mode)
         1: begin
            send_idle_pct = 49;
            stall_pct = 0;
         end
         2: begin
            send_idle_pct = 0;
            stall_pct = 49;
         end
         3: begin
            send_idle_pct = 13;
            stall_pct = 13;
         end
         default: begin
            send_idle_pct = 0;
            stall_pct = 0;
         end
      endcase
   endtask

   // ---------------------------------------------------------------------------
   // Test sequence.
   // ---------------------------------------------------------------------------
   initial begin
      int queued;
      int n_terms;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // With the point still at its reset value of zero: zero to the power zero
      // is one, while a positive power of zero wipes the term out.
      pending_terms.push_back(make_term(9, 0, 0, 0, 1'b1));
      pending_terms.push_back(make_term(4, 2, 0, 0, 1'b1));
      settle();

      write_point(2, -3, 0);
      // Coefficient extremes alone.
      pending_terms.push_back(make_term(32767, 0, 0, 0, 1'b1));
      pending_terms.push_back(make_term(-32768, 0, 0, 0, 1'b1));
      // Largest exponents on x and y across a two-term polynomial.
      pending_terms.push_back(make_term(5, 15, 0, 0, 1'b0));
      pending_terms.push_back(make_term(-1, 0, 15, 0, 1'b1));
      // A positive power of a zero coordinate.
      pending_terms.push_back(make_term(100, 0, 0, 1, 1'b1));
      // The product clamps, then the power of the zero z coordinate brings the
      // term to zero; the overflow flag must still come out set.
      pending_terms.push_back(make_term(7, 15, 15, 1, 1'b1));
      // The running sum clamps high, then a large negative term pulls it back.
      pending_terms.push_back(make_term(32767, 15, 0, 0, 1'b0));
      pending_terms.push_back(make_term(32767, 15, 0, 0, 1'b0));
      pending_terms.push_back(make_term(32767, 15, 0, 0, 1'b0));
      pending_terms.push_back(make_term(-32768, 15, 0, 0, 1'b1));
      // The running sum clamps low.
      pending_terms.push_back(make_term(-32768, 15, 0, 0, 1'b0));
      pending_terms.push_back(make_term(-32768, 15, 0, 0, 1'b0));
      pending_terms.push_back(make_term(-32768, 15, 0, 0, 1'b1));
      // Zero coefficient with every exponent at its maximum.
      pending_terms.push_back(make_term(0, 15, 15, 15, 1'b1));
      pending_terms.push_back(make_term(-1, 1, 1, 0, 1'b1));
      settle();

      // Register extremes: powers themselves clamp here.
      write_point(-32768, 32767, -1);
      pending_terms.push_back(make_term(1, 2, 0, 0, 1'b1));
      pending_terms.push_back(make_term(-1, 3, 0, 0, 1'b1));
      pending_terms.push_back(make_term(3, 0, 0, 15, 1'b0));
      pending_terms.push_back(make_term(3, 0, 0, 14, 1'b1));
      pending_terms.push_back(make_term(1, 0, 2, 0, 1'b1));
      pending_terms.push_back(make_term(1, 0, 3, 0, 1'b1));
      pending_terms.push_back(make_term(32767, 1, 1, 1, 1'b1));
      settle();

      // Random polynomials, a fresh point and idle pattern for each phase.
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         write_point(random_coord(), random_coord(), random_coord());
         set_idle_mode(phase % 4);
         queued = 0;
         while (queued < TERMS_PER_PHASE) begin
            n_terms = ($urandom_range(9) == 0) ? int'($urandom_range(20, 1))
                                               : int'($urandom_range(8, 1));
            for (int t = 0; t < n_terms; t++) begin
               pending_terms.push_back(make_term(random_signed16(), random_exp(),
                                                 random_exp(), random_exp(),
                                                 t == n_terms - 1));
            end
            queued += n_terms;
         end
         settle();
      end

      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

/* sim.f */
design/mpte_pkg.sv
design/mpte_sat_mul.sv
design/multivar_poly_term_evaluator_core.sv
sim/tb_top.sv
